/* src/byte_translate_delete_squeeze_defines.svh */
// Assertion macros shared by the filter RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef BYTE_TRANSLATE_DELETE_SQUEEZE_DEFINES_SVH
`define BYTE_TRANSLATE_DELETE_SQUEEZE_DEFINES_SVH

// same-cycle implication
`define BTS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("filter check failed");

// next-cycle implication
`define BTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("filter check failed");

`endif

/* src/bts_pkg.sv */
// Types and constants of the byte translate / delete / squeeze filter.
// No dependencies; used by the channel interfaces and the top level.
package bts_pkg;

   localparam int ByteW      = 8;
   localparam int TableDepth = 256;
   localparam int AddrW      = $clog2(TableDepth);
   localparam int ModeW      = 2;

   localparam logic ACTION_DATA = 1'b0;
   localparam logic ACTION_LOAD = 1'b1;

   typedef enum logic [ModeW-1:0] {
      MODE_TRANSLATE         = 2'd0,
      MODE_DELETE            = 2'd1,
      MODE_SQUEEZE           = 2'd2,
      MODE_SQUEEZE_TRANSLATE = 2'd3
   } mode_type;

   typedef struct packed {
      logic             member;
      logic [ByteW-1:0] repl;
   } entry_type;

endpackage

/* src/bts_req_if.sv */
// Request channel: data bytes and table loads.
// Depends on bts_pkg.
interface bts_req_if;
   import bts_pkg::*;

   logic             valid;
   logic             ready;
   logic             action;
   logic [ByteW-1:0] data_byte;
   logic             member;
   logic [ByteW-1:0] replacement;
   logic             last_in_block;

   modport source (output valid, action, data_byte, member, replacement, last_in_block,
                   input ready);
   modport sink   (input valid, action, data_byte, member, replacement, last_in_block,
                   output ready);
endinterface

/* src/bts_rsp_if.sv */
// Response channel: kept, possibly translated bytes.
// Depends on bts_pkg.
interface bts_rsp_if;
   import bts_pkg::*;

   logic             valid;
   logic             ready;
   logic [ByteW-1:0] out_byte;

   modport source (output valid, out_byte, input ready);
   modport sink   (input valid, out_byte, output ready);
endinterface

/* src/bts_csr_if.sv */
// Configuration write channel carrying the mode register.
// Depends on bts_pkg.
interface bts_csr_if;
   import bts_pkg::*;

   logic             valid;
   logic             ready;
   logic [ModeW-1:0] mode;

   modport source (output valid, mode, input ready);
   modport sink   (input valid, mode, output ready);
endinterface

/* src/byte_translate_delete_squeeze.sv */
// Top level of the tr-style byte filter: table memory, filter stage, output register.
// Depends on bts_pkg, the bts_*_if interfaces and the assertion macro header.
//
//  channel   dir  transaction
//  req_bus   in   data byte or table load (action selects)
//  rsp_bus   out  one kept byte per surviving data byte
//  csr_bus   in   mode register write, always ready
//
// One transaction per cycle while req_ready is high; a data byte reaches rsp through
// the registered table read in the filter stage and then the output register.
// Reset is synchronous; valid bits make every table entry read as a non-member that maps
// the byte to itself until loaded, so no clearing pass is needed.
// A stalled rsp holds a kept byte in the filter stage, and req_ready drops only while it is full.
`include "byte_translate_delete_squeeze_defines.svh"

module byte_translate_delete_squeeze (
   input  logic     clock,
   input  logic     reset,
   bts_req_if.sink  req_bus,
   bts_rsp_if.source rsp_bus,
   bts_csr_if.sink  csr_bus
);
   import bts_pkg::*;

   mode_type              mode_ff;
   entry_type             table_ff [TableDepth];
   logic [TableDepth-1:0] hit_ff;

   logic                  s1_valid_ff, s1_valid_in;
   logic [ByteW-1:0]      s1_byte_ff;
   logic                  s1_last_ff;
   logic                  s1_hit_ff;
   entry_type             s1_entry_ff;

   logic [ByteW-1:0]      prev_ff, prev_in;
   logic                  hist_ff, hist_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ByteW-1:0]      rsp_byte_ff;

   logic                  req_accept;
   logic                  s1_member;
   logic [ByteW-1:0]      s1_xlat;
   logic                  s1_match;
   logic                  s1_keep;
   logic [ByteW-1:0]      s1_result;
   logic                  out_free;
   logic                  s1_advance;
   logic                  rsp_load;

   assign req_accept  = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TRANSLATE;
      end else if (csr_bus.valid && csr_bus.ready) begin
         mode_ff <= mode_type'(csr_bus.mode);
      end
   end

   // table memory: write on load, registered read on data
   always_ff @(posedge clock) begin
      if (req_accept && req_bus.action == ACTION_LOAD) begin
         table_ff[req_bus.data_byte] <= '{member: req_bus.member, repl: req_bus.replacement};
      end
      if (req_accept && req_bus.action == ACTION_DATA) begin
         s1_entry_ff <= table_ff[req_bus.data_byte];
         s1_hit_ff   <= hit_ff[req_bus.data_byte];
         s1_byte_ff  <= req_bus.data_byte;
         s1_last_ff  <= req_bus.last_in_block;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= '0;
      end else if (req_accept && req_bus.action == ACTION_LOAD) begin
         hit_ff[req_bus.data_byte] <= 1'b1;
      end
   end

   always_comb begin
      s1_member = s1_hit_ff & s1_entry_ff.member;
      s1_xlat   = s1_hit_ff ? s1_entry_ff.repl : s1_byte_ff;
      s1_match  = s1_member && hist_ff && (s1_byte_ff == prev_ff);
      case (mode_ff)
         MODE_TRANSLATE: begin
            s1_keep   = 1'b1;
            s1_result = s1_xlat;
         end
         MODE_DELETE: begin
            s1_keep   = !s1_member;
            s1_result = s1_byte_ff;
         end
         MODE_SQUEEZE: begin
            s1_keep   = !s1_match;
            s1_result = s1_byte_ff;
         end
         MODE_SQUEEZE_TRANSLATE: begin
            s1_keep   = !s1_match;
            s1_result = s1_xlat;
         end
         default: begin
            s1_keep   = 1'b1;
            s1_result = s1_xlat;
         end
      endcase

      out_free      = !rsp_valid_ff || rsp_bus.ready;
      s1_advance    = s1_valid_ff && (!s1_keep || out_free);
      rsp_load      = s1_advance && s1_keep;
      req_bus.ready = !s1_valid_ff || s1_advance;
      s1_valid_in   = (s1_valid_ff && !s1_advance) ||
                      (req_accept && req_bus.action == ACTION_DATA);
      rsp_valid_in  = rsp_load || (rsp_valid_ff && !rsp_bus.ready);

      prev_in = prev_ff;
      hist_in = hist_ff;
      if (s1_advance) begin
         if (s1_keep) begin
            prev_in = s1_byte_ff;
            hist_in = 1'b1;
         end
         if (s1_last_ff) begin
            hist_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         hist_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         hist_ff      <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_byte_ff <= s1_result;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_byte_ff;

   `BTS_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_load, !rsp_valid_ff || rsp_bus.ready)
   `BTS_ASSERT_NEXT(a_load_no_stage, clock, reset,
      req_accept && req_bus.action == ACTION_LOAD, !s1_valid_ff)
   `BTS_ASSERT_NEXT(a_last_clears, clock, reset, s1_advance && s1_last_ff, !hist_ff)
   `BTS_ASSERT_NOW(a_squeeze_drop, clock, reset,
      s1_advance && s1_keep && s1_member && hist_ff &&
      (mode_ff == MODE_SQUEEZE || mode_ff == MODE_SQUEEZE_TRANSLATE),
      s1_byte_ff != prev_ff)

endmodule

/* dv/byte_translate_delete_squeeze_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for byte_translate_delete_squeeze: table loads, all four modes,
// squeeze history across blocks and mode changes. Depends on bts_pkg, the bts_*_if
// interfaces and the filter RTL; a local predictor supplies the expected bytes.
module byte_translate_delete_squeeze_tb;
   import bts_pkg::*;

   typedef struct packed {
      logic             action;
      logic [ByteW-1:0] data_byte;
      logic             member;
      logic [ByteW-1:0] replacement;
      logic             last_in_block;
   } req_item_type;

   logic clock = 1'b0;
   logic reset;

   bts_req_if req_bus();
   bts_rsp_if rsp_bus();
   bts_csr_if csr_bus();

   byte_translate_delete_squeeze DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   logic             member_set [TableDepth];
   logic [ByteW-1:0] xlat_table [TableDepth];
   logic [ByteW-1:0] last_kept;
   logic             history_live;
   mode_type         cur_mode;

   req_item_type     pending_q [$];
   logic [ByteW-1:0] kept_bytes_q [$];
   logic [ByteW-1:0] alphabet [8];

   int req_idle_pct;
   int rsp_stall_pct;
   int mismatches;
   int sent_count;
   int load_count;
   int checked_count;

   always #5 clock = ~clock;

   task automatic filter_transaction(input req_item_type it);
      logic             keep;
      logic             squeezable;
      logic [ByteW-1:0] result;
      if (it.action == ACTION_LOAD) begin
         member_set[it.data_byte] = it.member;
         xlat_table[it.data_byte] = it.replacement;
         load_count++;
      end else begin
         keep       = 1'b1;
         result     = it.data_byte;
         squeezable = member_set[it.data_byte] && history_live
                      && (it.data_byte == last_kept);
         case (cur_mode)
            MODE_TRANSLATE: begin
               result = xlat_table[it.data_byte];
            end
            MODE_DELETE: begin
               keep = !member_set[it.data_byte];
            end
            MODE_SQUEEZE: begin
               keep = !squeezable;
            end
            default: begin
               keep   = !squeezable;
               result = xlat_table[it.data_byte];
            end
         endcase
         if (keep) begin
            last_kept    = it.data_byte;
            history_live = 1'b1;
            kept_bytes_q.push_back(result);
         end
         if (it.last_in_block) history_live = 1'b0;
      end
   endtask

   always @(posedge clock) begin : req_driver
      req_item_type seen;
      req_item_type next_item;
      if (reset) begin
         req_bus.valid         <= 1'b0;
         req_bus.action        <= ACTION_DATA;
         req_bus.data_byte     <= '0;
         req_bus.member        <= 1'b0;
         req_bus.replacement   <= '0;
         req_bus.last_in_block <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            seen.action        = req_bus.action;
            seen.data_byte     = req_bus.data_byte;
            seen.member        = req_bus.member;
            seen.replacement   = req_bus.replacement;
            seen.last_in_block = req_bus.last_in_block;
            filter_transaction(seen);
            sent_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
               next_item = pending_q.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.action        <= next_item.action;
               req_bus.data_byte     <= next_item.data_byte;
               req_bus.member        <= next_item.member;
               req_bus.replacement   <= next_item.replacement;
               req_bus.last_in_block <= next_item.last_in_block;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      logic [ByteW-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         checked_count++;
         if (kept_bytes_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected output byte %02h, nothing expected", rsp_bus.out_byte);
         end else begin
            want = kept_bytes_q.pop_front();
            if (rsp_bus.out_byte !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("out_byte mismatch: expected %02h, got %02h",
                           want, rsp_bus.out_byte);
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   task automatic queue_data(input logic [ByteW-1:0] b, input logic last);
      req_item_type it;
      it.action        = ACTION_DATA;
      it.data_byte     = b;
      it.member        = 1'($urandom_range(0, 1));
      it.replacement   = ByteW'($urandom_range(0, 255));
      it.last_in_block = last;
      pending_q.push_back(it);
   endtask

   task automatic queue_load(input logic [ByteW-1:0] idx, input logic mem,
                             input logic [ByteW-1:0] repl, input logic last);
      req_item_type it;
      it.action        = ACTION_LOAD;
      it.data_byte     = idx;
      it.member        = mem;
      it.replacement   = repl;
      it.last_in_block = last;
      pending_q.push_back(it);
   endtask

   task automatic wait_idle();
      while (pending_q.size() != 0 || req_bus.valid || kept_bytes_q.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_mode(input mode_type m);
      wait_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.mode  <= m;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      cur_mode = m;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic queue_random_phase(input int n);
      int               made;
      int               run;
      logic [ByteW-1:0] pick;
      made = 0;
      foreach (alphabet[i]) begin
         alphabet[i] = ByteW'($urandom_range(0, 255));
         queue_load(alphabet[i], 1'($urandom_range(0, 1)), ByteW'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
         made++;
      end
      while (made < n) begin
         if ($urandom_range(0, 4) != 0) pick = alphabet[3'($urandom_range(0, 7))];
         else pick = ByteW'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < 12) begin
            queue_load(pick, 1'($urandom_range(0, 1)), ByteW'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
            made++;
         end else begin
            run = $urandom_range(1, 4);
            repeat (run) queue_data(pick, $urandom_range(0, 11) == 0);
            made += run;
         end
      end
   endtask

   initial begin
      #2_000_000;
      $display("byte_translate_delete_squeeze_tb: FAIL");
      $finish;
   end

   initial begin
      for (int i = 0; i < TableDepth; i++) begin
         member_set[i] = 1'b0;
         xlat_table[i] = ByteW'(i);
      end
      last_kept     = '0;
      history_live  = 1'b0;
      cur_mode      = MODE_TRANSLATE;
      mismatches    = 0;
      sent_count    = 0;
      load_count    = 0;
      checked_count = 0;
      req_idle_pct  = 37;
      rsp_stall_pct = 69;

      reset                 = 1'b1;
      csr_bus.valid         = 1'b0;
      csr_bus.mode          = MODE_TRANSLATE;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // identity table after reset, then loaded entries at both ends of the range
      queue_data(8'h00, 1'b0);
      queue_data(8'hFF, 1'b1);
      queue_load(8'h41, 1'b1, 8'hFF, 1'b0);
      queue_load(8'hFF, 1'b1, 8'h00, 1'b0);
      queue_load(8'h00, 1'b0, 8'hA5, 1'b0);
      queue_data(8'h41, 1'b0);
      queue_data(8'hFF, 1'b0);
      queue_data(8'h00, 1'b0);

      // squeeze: repeats, last on a load, last on a dropped byte, new block
      write_mode(MODE_SQUEEZE);
      queue_data(8'h41, 1'b0);
      queue_data(8'h41, 1'b0);
      queue_load(8'h41, 1'b1, 8'h42, 1'b1);
      queue_data(8'h41, 1'b0);
      queue_data(8'h41, 1'b1);
      queue_data(8'h41, 1'b0);
      queue_data(8'h00, 1'b0);
      queue_data(8'h00, 1'b0);

      write_mode(MODE_DELETE);
      queue_data(8'hFF, 1'b0);
      queue_data(8'h12, 1'b0);
      queue_data(8'h41, 1'b0);

      // history carries over from delete mode
      write_mode(MODE_SQUEEZE_TRANSLATE);
      queue_data(8'hFF, 1'b0);
      queue_data(8'hFF, 1'b0);
      queue_data(8'hFF, 1'b1);
      queue_data(8'hFF, 1'b0);
      queue_data(8'h41, 1'b0);

      for (int ph = 0; ph < 9; ph++) begin
         write_mode(mode_type'(ph % 4));
         if (ph == 3) begin
            req_idle_pct  = 69;
            rsp_stall_pct = 37;
         end
         if (ph == 6) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         queue_random_phase(192);
      end

      wait_idle();
      $display("%0d transactions sent (%0d table loads), %0d output bytes checked",
               sent_count, load_count, checked_count);
      $display("all four modes under three idle patterns, %0d mismatches", mismatches);
      if (mismatches == 0 && kept_bytes_q.size() == 0) begin
         $display("byte_translate_delete_squeeze_tb: PASS");
      end else begin
         $display("byte_translate_delete_squeeze_tb: FAIL");
      end
      $finish;
   end

endmodule

/* byte_translate_delete_squeeze.f */
+incdir+src
src/bts_pkg.sv
src/bts_req_if.sv
src/bts_rsp_if.sv
src/bts_csr_if.sv
src/byte_translate_delete_squeeze.sv
dv/byte_translate_delete_squeeze_tb.sv
